// ===== rtl/hfl_pkg.sv =====
// ----------------------------------------------------------------------------
// hfl_pkg: shared types and constants of the header field locator
// Register indexes, status codes, byte constants and the cell status bundle.
// ----------------------------------------------------------------------------
package hfl_pkg;

    localparam int MAX_PATTERN_BYTES = 8;
    localparam int MAX_PAYLOAD_BYTES = 2048;

    localparam int IDX_W  = 12;
    localparam int OUT_W  = 11;
    localparam logic [IDX_W-1:0] IDX_MAX = 12'hFFF;
    localparam int OUT_MAX_INT = (MAX_PAYLOAD_BYTES - 1) < 2047 ? (MAX_PAYLOAD_BYTES - 1) : 2047;
    localparam logic [OUT_W-1:0] OUT_MAX = OUT_W'(OUT_MAX_INT);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [2:0] HDR_END_STATE = 3'd4;

    localparam logic [63:0] PATTERN_RESET = 64'h0000_0000_2054_4547;
    localparam logic [3:0]  PLEN_RESET    = 4'd4;
    localparam logic [7:0]  TERM_RESET    = 8'h0D;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES   = 2'd0,
        REG_PATTERN_LENGTH  = 2'd1,
        REG_TERMINATOR_BYTE = 2'd2,
        REG_UNUSED          = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_NOT_FOUND  = 2'd0,
        ST_FOUND      = 2'd1,
        ST_INCOMPLETE = 2'd2
    } status_t;

    // What one cell reports to the top level in each cycle
    typedef struct packed {
        logic       hit;
        logic [7:0] cand;
    } cell_stat_t;

    // Fold ASCII upper case to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
            r = c + 8'h20;
        return r;
    endfunction

endpackage

// ===== rtl/header_field_locator.sv =====
// ----------------------------------------------------------------------------
// header_field_locator: pattern search over a header byte stream
// Finds a configured pattern before the blank line that ends the header and
// measures the field value that follows it up to a terminator byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one payload byte per transfer,
//   with last_byte set on the final byte. Output channel (out_valid/out_ready)
//   carries exactly one result per payload: status, value_offset and
//   value_length, produced by the transfer of the byte marked last.
//   Configuration channel (cfg_valid/cfg_ready) writes pattern_bytes,
//   pattern_length or terminator_byte; cfg_ready is always high. Write only
//   while no payload is in flight.
//   Throughput: one byte per cycle unless a result waits on out_ready. The
//   comparison window is a row of eight cells that shift one byte per
//   transfer, so every byte is handled in the cycle it is accepted.
//   Result: the result appears in the output register in the cycle after the
//   last byte is accepted.
//   Stall: while a result waits and out_ready is low, in_ready is low; the
//   transfer that takes the result frees the block in the same cycle.
//   Reset: configuration registers return to their defaults (pattern "GET ", length 4,
//   terminator CR) and all per-payload state clears.
// ----------------------------------------------------------------------------
module header_field_locator
    import hfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [10:0] value_offset,
    output logic [10:0] value_length,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NUM_CELLS = MAX_PATTERN_BYTES;

    // Configuration registers
    logic [63:0] pattern_reg;
    logic [3:0]  plen_reg;
    logic [7:0]  term_reg;

    // Per-payload state
    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [2:0]       blank_reg, blank_next;
    logic             hdr_end_reg, hdr_end_next;
    logic             match_reg, match_next;
    logic [OUT_W-1:0] offset_reg, offset_next;
    logic [OUT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic             prefix_ok_reg, prefix_ok_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [OUT_W-1:0] out_off_reg, out_off_next;
    logic [OUT_W-1:0] out_len_reg, out_len_next;

    logic             in_xfer;
    logic             clear_xfer;
    logic [2:0]       plen_m1;
    logic [7:0]       byte_chain [NUM_CELLS];
    cell_stat_t       cell_stat  [NUM_CELLS];
    logic [NUM_CELLS-1:0] hit_vec;
    logic [7:0]       cand_byte;
    logic             window_eq;
    logic             short_payload;
    logic             cand_ok;
    logic [IDX_W:0]   n_plus1;
    logic [7:0]       prefix_pat;
    logic [1:0]       status_sel;

    assign cfg_ready  = 1'b1;
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_xfer    = in_valid && in_ready;
    assign clear_xfer = in_xfer && last_byte;

    // Clamp the pattern length into 1..8 and keep it as length minus one
    always_comb
    begin
        if (plen_reg == 4'd0)
            plen_m1 = 3'd0;
        else if (plen_reg > 4'(MAX_PATTERN_BYTES))
            plen_m1 = 3'(MAX_PATTERN_BYTES - 1);
        else
            plen_m1 = 3'(plen_reg - 4'd1);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= PATTERN_RESET;
            plen_reg    <= PLEN_RESET;
            term_reg    <= TERM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PATTERN_BYTES:   pattern_reg <= cfg_data;
                REG_PATTERN_LENGTH:  plen_reg    <= cfg_data[3:0];
                REG_TERMINATOR_BYTE: term_reg    <= cfg_data[7:0];
                default:             ;
            endcase
        end
    end

    // Window of recent bytes: cell i sees the byte i places back
    assign byte_chain[0] = data_byte;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_CELLS; gi++)
        begin : g_cell
            if (gi < NUM_CELLS - 1)
            begin : g_link
                hfl_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_xfer),
                    .clear    (last_byte),
                    .cell_pos (3'(gi)),
                    .pattern  (pattern_reg),
                    .plen_m1  (plen_m1),
                    .in_byte  (byte_chain[gi]),
                    .out_byte (byte_chain[gi+1]),
                    .stat     (cell_stat[gi])
                );
            end
            else
            begin : g_tail
                hfl_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (in_xfer),
                    .clear    (last_byte),
                    .cell_pos (3'(gi)),
                    .pattern  (pattern_reg),
                    .plen_m1  (plen_m1),
                    .in_byte  (byte_chain[gi]),
                    .out_byte (),
                    .stat     (cell_stat[gi])
                );
            end
        end
    endgenerate

    // Gather the cell reports
    always_comb
    begin
        cand_byte = 8'h00;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            hit_vec[i] = cell_stat[i].hit;
            cand_byte  = cand_byte | cell_stat[i].cand;
        end
    end

    assign window_eq     = &hit_vec;
    assign short_payload = byte_index_reg <= IDX_W'(plen_m1);
    assign cand_ok       = byte_index_reg >= IDX_W'(plen_m1);
    assign n_plus1       = {1'b0, byte_index_reg} + (IDX_W+1)'(1);
    assign prefix_pat    = pattern_reg[{byte_index_reg[2:0], 3'b000} +: 8];

    // Per-byte update of the search state
    always_comb
    begin
        byte_index_next = byte_index_reg;
        blank_next      = blank_reg;
        hdr_end_next    = hdr_end_reg;
        match_next      = match_reg;
        offset_next     = offset_reg;
        count_next      = count_reg;
        closed_next     = closed_reg;
        prefix_ok_next  = prefix_ok_reg;

        if (in_xfer)
        begin
            // Track the caseless prefix for short payloads
            if (short_payload && fold_case(data_byte) != fold_case(prefix_pat))
                prefix_ok_next = 1'b0;

            // Measure the field value after a match
            if (match_reg && !closed_reg)
            begin
                if (data_byte == term_reg)
                    closed_next = 1'b1;
                else if (count_reg < OUT_MAX)
                    count_next = count_reg + OUT_W'(1);
            end

            // Check the candidate start for the blank line, then for the pattern
            if (cand_ok && !hdr_end_reg && !match_reg)
            begin
                if (cand_byte == CH_CR)
                    blank_next = blank_reg[0] ? 3'd0 : blank_reg + 3'd1;
                else if (cand_byte == CH_LF)
                    blank_next = blank_reg[0] ? blank_reg + 3'd1 : 3'd0;
                else
                    blank_next = 3'd0;

                if (blank_next >= HDR_END_STATE)
                    hdr_end_next = 1'b1;
                else if (window_eq)
                begin
                    match_next  = 1'b1;
                    offset_next = (n_plus1 > (IDX_W+1)'(OUT_MAX)) ? OUT_MAX
                                                                : n_plus1[OUT_W-1:0];
                end
            end

            if (byte_index_reg < IDX_MAX)
                byte_index_next = byte_index_reg + IDX_W'(1);
        end
    end

    // Pick the outcome of the payload
    always_comb
    begin
        if (short_payload)
            status_sel = prefix_ok_next ? ST_INCOMPLETE : ST_NOT_FOUND;
        else if (match_next)
            status_sel = closed_next ? ST_FOUND : ST_INCOMPLETE;
        else
            status_sel = ST_NOT_FOUND;
    end

    // Load the result register on the last byte, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        out_off_next   = out_off_reg;
        out_len_next   = out_len_reg;
        if (clear_xfer)
        begin
            out_valid_next = 1'b1;
            status_next    = status_sel;
            if (status_sel == ST_FOUND)
            begin
                out_off_next = offset_next;
                out_len_next = count_next;
            end
            else
            begin
                out_off_next = '0;
                out_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            blank_reg      <= '0;
            hdr_end_reg    <= 1'b0;
            match_reg      <= 1'b0;
            offset_reg     <= '0;
            count_reg      <= '0;
            closed_reg     <= 1'b0;
            prefix_ok_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (clear_xfer)
            begin
                byte_index_reg <= '0;
                blank_reg      <= '0;
                hdr_end_reg    <= 1'b0;
                match_reg      <= 1'b0;
                offset_reg     <= '0;
                count_reg      <= '0;
                closed_reg     <= 1'b0;
                prefix_ok_reg  <= 1'b1;
            end
            else
            begin
                byte_index_reg <= byte_index_next;
                blank_reg      <= blank_next;
                hdr_end_reg    <= hdr_end_next;
                match_reg      <= match_next;
                offset_reg     <= offset_next;
                count_reg      <= count_next;
                closed_reg     <= closed_next;
                prefix_ok_reg  <= prefix_ok_next;
            end
        end
    end

    // Result payload holds without reset
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        out_off_reg <= out_off_next;
        out_len_reg <= out_len_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign value_offset = out_off_reg;
    assign value_length = out_len_reg;

endmodule

// ===== rtl/hfl_cell.sv =====
// ----------------------------------------------------------------------------
// hfl_cell: one window cell of the header field locator
// Holds one recent byte, compares the byte at its window place with the
// pattern byte that lines up with it, and hands the byte to its neighbor.
// ----------------------------------------------------------------------------
module hfl_cell
    import hfl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift_en,
    input  logic        clear,
    input  logic [2:0]  cell_pos,
    input  logic [63:0] pattern,
    input  logic [2:0]  plen_m1,
    input  logic [7:0]  in_byte,
    output logic [7:0]  out_byte,
    output cell_stat_t  stat
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [2:0] pat_idx;
    logic [7:0] pat_byte;

    // Pick the pattern byte that aligns with this window place
    assign pat_idx  = plen_m1 - cell_pos;
    assign pat_byte = pattern[{pat_idx, 3'b000} +: 8];

    // Places beyond the pattern always agree; the oldest place gives the candidate
    assign stat.hit  = (cell_pos > plen_m1) || (in_byte == pat_byte);
    assign stat.cand = (cell_pos == plen_m1) ? in_byte : 8'h00;

    // Advance on each transfer, drop to zero at payload end
    always_comb
    begin
        byte_next = byte_reg;
        if (shift_en)
            byte_next = clear ? 8'h00 : in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byte_reg <= 8'h00;
        else
            byte_reg <= byte_next;
    end

    assign out_byte = byte_reg;

endmodule

// ===== rtl/hfl_checker.sv =====
// ----------------------------------------------------------------------------
// hfl_checker: port-level checks of the header field locator
// Watches the channels of the top level and flags broken result behavior.
// ----------------------------------------------------------------------------
module hfl_checker
    import hfl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [10:0] value_offset,
    input logic [10:0] value_length
);

    // Status code is one of the three outcomes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_NOT_FOUND || status == ST_FOUND ||
                       status == ST_INCOMPLETE))
        else $error("status code out of range");

    // Offset and length are zero unless found
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_FOUND) |-> (value_offset == '0 && value_length == '0))
        else $error("nonzero fields on a result that is not found");

    // A stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) &&
                                       $stable(value_offset) && $stable(value_length)))
        else $error("stalled result changed");

    // The last byte produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_byte) |=> out_valid)
        else $error("no result after last byte");

    // Other bytes produce no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last_byte && (!out_valid || out_ready)) |=> !out_valid)
        else $error("result without a last byte");

endmodule

bind header_field_locator hfl_checker u_hfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .value_offset (value_offset),
    .value_length (value_length)
);
